// ===== hw/rtl/dmm_pkg.sv =====
// ============================================================================
// dmm_pkg
// Shared types and constants of the dense matrix multiply core.
// ============================================================================
`default_nettype none

package dmm_pkg;

    // Default sizing of the core.
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths on the ports.
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 32;
    localparam int SIZE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int PROD_W    = 2 * VAL_W;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS   = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Request kinds carried on s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } seq_state_t;

    // Store write strobes from the sequencer.
    typedef struct packed {
        logic left;
        logic right;
    } wr_t;

    // One multiply-accumulate step issued to the datapath.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             elem_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } issue_t;

    // One finished product element.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dmm_ram.sv =====
// ============================================================================
// dmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module dmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dmm_seq.sv =====
// ============================================================================
// dmm_seq
// Request sequencer: store writes and the row/column/inner walk of a compute.
// ============================================================================
`default_nettype none

module dmm_seq #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [dmm_pkg::SIZE_W-1:0]           left_rows,
    input  logic [dmm_pkg::SIZE_W-1:0]           inner_length,
    input  logic [dmm_pkg::SIZE_W-1:0]           right_cols,
    input  logic                                 in_valid,
    input  logic [dmm_pkg::OP_W-1:0]             in_op,
    input  logic [dmm_pkg::IDX_W-1:0]            in_row,
    input  logic [dmm_pkg::IDX_W-1:0]            in_col,
    output logic                                 in_ready,
    input  logic                                 elem_done,
    output dmm_pkg::wr_t                         wr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_left_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_right_addr,
    output dmm_pkg::issue_t                      issue
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    dmm_pkg::seq_state_t state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] rlim_reg, rlim_next;
    logic [IW-1:0] klim_reg, klim_next;
    logic [IW-1:0] clim_reg, clim_next;
    logic          in_range;
    logic          elem_last;

    // Last valid index for a size register: zero acts as one, large values clip.
    function automatic logic [IW-1:0] last_index(input logic [dmm_pkg::SIZE_W-1:0] v);
        logic [IW-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (v > dmm_pkg::SIZE_W'(MAX_DIM))
        begin
            r = IW'(MAX_DIM - 1);
        end
        else
        begin
            r = IW'(v - dmm_pkg::SIZE_W'(1));
        end
        return r;
    endfunction

    assign in_range = ({1'b0, in_row} < (dmm_pkg::IDX_W + 1)'(MAX_DIM))
                   && ({1'b0, in_col} < (dmm_pkg::IDX_W + 1)'(MAX_DIM));
    assign wr_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
    assign rd_left_addr  = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign rd_right_addr = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);
    assign elem_last = (i_reg == rlim_reg) && (j_reg == clim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            rlim_reg  <= '0;
            klim_reg  <= '0;
            clim_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            rlim_reg  <= rlim_next;
            klim_reg  <= klim_next;
            clim_reg  <= clim_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        rlim_next  = rlim_reg;
        klim_next  = klim_reg;
        clim_next  = clim_reg;
        in_ready   = 1'b0;
        wr         = '0;
        issue      = '0;

        unique case (state_reg)
            dmm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (dmm_pkg::op_t'(in_op))
                        dmm_pkg::OP_LOAD_LEFT:
                        begin
                            wr.left = in_range;
                        end
                        dmm_pkg::OP_LOAD_RIGHT:
                        begin
                            wr.right = in_range;
                        end
                        dmm_pkg::OP_COMPUTE:
                        begin
                            rlim_next  = last_index(left_rows);
                            klim_next  = last_index(inner_length);
                            clim_next  = last_index(right_cols);
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = dmm_pkg::ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            dmm_pkg::ST_RUN:
            begin
                issue.valid     = 1'b1;
                issue.first     = (k_reg == '0);
                issue.last      = (k_reg == klim_reg);
                issue.elem_last = elem_last;
                issue.row       = dmm_pkg::IDX_W'(i_reg);
                issue.col       = dmm_pkg::IDX_W'(j_reg);
                if (k_reg == klim_reg)
                begin
                    k_next     = '0;
                    state_next = dmm_pkg::ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            dmm_pkg::ST_WAIT:
            begin
                // The element has left the datapath; step to the next one.
                if (elem_done)
                begin
                    if (elem_last)
                    begin
                        state_next = dmm_pkg::ST_IDLE;
                    end
                    else if (j_reg == clim_reg)
                    begin
                        j_next     = '0;
                        i_next     = i_reg + IW'(1);
                        state_next = dmm_pkg::ST_RUN;
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = dmm_pkg::ST_RUN;
                    end
                end
            end

            default:
            begin
                state_next = dmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dmm_mac.sv =====
// ============================================================================
// dmm_mac
// Multiply-accumulate datapath with round-toward-zero and saturation.
// ============================================================================
`default_nettype none

module dmm_mac #(
    parameter int MAX_DIM   = dmm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dmm_pkg::issue_t              issue,
    input  logic [dmm_pkg::VAL_W-1:0]    a_data,
    input  logic [dmm_pkg::VAL_W-1:0]    b_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output dmm_pkg::result_t             res
);

    localparam int ACC_W = dmm_pkg::PROD_W + $clog2(MAX_DIM);
    localparam int Q_W   = ACC_W - FRAC_BITS;
    localparam int VW    = dmm_pkg::VAL_W;

    dmm_pkg::issue_t          d_tag_reg;
    dmm_pkg::issue_t          p_tag_reg;
    dmm_pkg::issue_t          a_tag_reg;
    dmm_pkg::issue_t          q_tag_reg;
    logic signed [dmm_pkg::PROD_W-1:0] prod;
    logic signed [dmm_pkg::PROD_W-1:0] p_reg;
    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_biased;
    logic        [Q_W-1:0]    q_reg;
    logic                     q_valid_reg;
    logic                     a_fin;
    logic                     in_range;

    // Store data arrives in the cycle after the issue.
    assign prod  = $signed(a_data) * $signed(b_data);
    assign p_ext = {{(ACC_W - dmm_pkg::PROD_W){p_reg[dmm_pkg::PROD_W-1]}}, p_reg};
    assign a_fin = a_tag_reg.valid && a_tag_reg.last;

    // Adding 2^F-1 to a negative sum turns the floor of the shift into truncation.
    assign acc_biased = acc_reg
                      + {{(ACC_W - FRAC_BITS){1'b0}}, {FRAC_BITS{acc_reg[ACC_W-1]}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_tag_reg   <= '0;
            p_tag_reg   <= '0;
            a_tag_reg   <= '0;
            q_tag_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            d_tag_reg <= issue;
            p_tag_reg <= d_tag_reg;
            a_tag_reg <= p_tag_reg;
            if (a_fin)
            begin
                q_tag_reg   <= a_tag_reg;
                q_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                q_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        if (p_tag_reg.valid)
        begin
            acc_reg <= p_tag_reg.first ? p_ext : acc_reg + p_ext;
        end
        if (a_fin)
        begin
            q_reg <= acc_biased[ACC_W-1:FRAC_BITS];
        end
    end

    // The quotient fits when every bit from bit 31 up equals the sign.
    assign in_range = (q_reg[Q_W-1:VW-1] == '0) || (q_reg[Q_W-1:VW-1] == '1);

    assign res_valid = q_valid_reg;

    always_comb
    begin
        res.row  = q_tag_reg.row;
        res.col  = q_tag_reg.col;
        res.last = q_tag_reg.elem_last;
        res.sat  = !in_range;
        if (in_range)
        begin
            res.value = q_reg[VW-1:0];
        end
        else if (q_reg[Q_W-1])
        begin
            res.value = {1'b1, {(VW - 1){1'b0}}};
        end
        else
        begin
            res.value = {1'b0, {(VW - 1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dense_matrix_multiply_core.sv =====
// ============================================================================
// dense_matrix_multiply_core
// Signed fixed-point matrix multiply with element-wise load and streamed result.
// ============================================================================
// Usage:
// Requests enter on the s_ channel. s_tuser selects the kind: load a left
// element, load a right element, or compute. A load writes element_value at
// (row_index, col_index) of its store; an index at or above MAX_DIM is
// dropped. A compute request streams the product matrix on the m_ channel
// in row-major order, one element per transfer, with tlast on the final
// one and tuser set where the value was clipped to 32 bits.
// The sizes come from three registers on the cfg_ channel, to be written
// only while the core is idle (the core itself does not enforce this);
// each resets to 8, zero acts as one and a size above MAX_DIM acts as MAX_DIM.
// Each product element runs its store reads through the single shared
// multiply-accumulate unit, and the datapath finishes one element before
// the sequencer issues the next. s_tready stays low until the last element
// has entered the output register.
// A stalled receiver holds the current element in the output register; the
// next element is computed meanwhile and waits at the end of the datapath.
// Reset returns the control state to idle and the size registers to 8; the
// store contents are undefined until written.
// ============================================================================
`default_nettype none

module dense_matrix_multiply_core #(
    parameter int MAX_DIM   = dmm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: row_index[2:0], col_index[5:3], element_value[37:6], zero pad
    input  logic [dmm_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [dmm_pkg::OP_W-1:0]          s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: out_row[2:0], out_col[5:3], product_value[37:6], zero pad
    output logic [dmm_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: saturated[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmm_pkg::SIZE_W-1:0]        cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IXW   = dmm_pkg::IDX_W;
    localparam int VW    = dmm_pkg::VAL_W;

    logic [dmm_pkg::SIZE_W-1:0] left_rows_reg;
    logic [dmm_pkg::SIZE_W-1:0] inner_length_reg;
    logic [dmm_pkg::SIZE_W-1:0] right_cols_reg;

    logic [IXW-1:0]      in_row;
    logic [IXW-1:0]      in_col;
    logic [VW-1:0]       in_value;

    dmm_pkg::wr_t        wr;
    dmm_pkg::issue_t     issue;
    dmm_pkg::result_t    res;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_left_addr;
    logic [AW-1:0]       rd_right_addr;
    logic [VW-1:0]       left_rdata;
    logic [VW-1:0]       right_rdata;
    logic                res_valid;
    logic                res_ready;
    logic                elem_done;

    logic                m_valid_reg;
    dmm_pkg::result_t    m_res_reg;

    assign in_row   = s_tdata[IXW-1:0];
    assign in_col   = s_tdata[2*IXW-1:IXW];
    assign in_value = s_tdata[2*IXW+VW-1:2*IXW];

    // Size registers. Writes to an index past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_rows_reg    <= dmm_pkg::SIZE_RESET;
            inner_length_reg <= dmm_pkg::SIZE_RESET;
            right_cols_reg   <= dmm_pkg::SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dmm_pkg::REG_LEFT_ROWS:    left_rows_reg    <= cfg_data;
                dmm_pkg::REG_INNER_LENGTH: inner_length_reg <= cfg_data;
                dmm_pkg::REG_RIGHT_COLS:   right_cols_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dmm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .left_rows     (left_rows_reg),
        .inner_length  (inner_length_reg),
        .right_cols    (right_cols_reg),
        .in_valid      (s_tvalid),
        .in_op         (s_tuser),
        .in_row        (in_row),
        .in_col        (in_col),
        .in_ready      (s_tready),
        .elem_done     (elem_done),
        .wr            (wr),
        .wr_addr       (wr_addr),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .issue         (issue)
    );

    // Loads only happen while no compute is running, so the stores never see
    // a write and a read of the same entry in flight together.
    dmm_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (wr.left),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (issue.valid),
        .raddr (rd_left_addr),
        .rdata (left_rdata)
    );

    dmm_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (wr.right),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (issue.valid),
        .raddr (rd_right_addr),
        .rdata (right_rdata)
    );

    dmm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .a_data    (left_rdata),
        .b_data    (right_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: it takes a new element when empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;
    assign elem_done = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_done)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dmm_pkg::M_TDATA_W - 2*IXW - VW){1'b0}},
                       m_res_reg.value, m_res_reg.col, m_res_reg.row};
    assign m_tuser  = m_res_reg.sat;
    assign m_tlast  = m_res_reg.last;

endmodule

`default_nettype wire

// ===== hw/rtl/dmm_checker.sv =====
// ============================================================================
// dmm_checker
// Port-level checks of the dense matrix multiply core, bound to the top level.
// ============================================================================
`default_nettype none

module dmm_checker #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [dmm_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dmm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A clipped element carries one of the two rail values.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[37:6] == 32'h7FFF_FFFF
                             || m_tdata[37:6] == 32'h8000_0000)
        else $error("saturated element off the rails");

    // Product coordinates stay inside the store geometry.
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[2:0]} < 4'(MAX_DIM))
                  && ({1'b0, m_tdata[5:3]} < 4'(MAX_DIM)))
        else $error("product coordinate out of range");

    // An accepted compute request blocks further requests.
    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == dmm_pkg::OP_COMPUTE |=> !s_tready)
        else $error("request accepted during a compute");

endmodule

bind dense_matrix_multiply_core dmm_checker #(
    .MAX_DIM (MAX_DIM)
) u_dmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Self-checking testbench of dense_matrix_multiply_core. Loads both element
// stores over the request stream, runs compute requests at many matrix sizes
// and checks every streamed product element against a fixed-point product
// worked out here from its own copy of the stores and size registers.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmm_pkg::*;

    // Codes that have no name in the package: the spare request kind and the
    // spare register index. The core must ignore both.
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int DIM           = MAX_DIM_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int TOTAL_ITEMS   = 470;
    // Cycles allowed after the last result before the core counts as idle.
    // The datapath is four deep, so this is ample.
    localparam int SETTLE_CYCLES = 12;
    localparam int END_WAIT      = 200000;
    localparam int PRINT_LIMIT   = 40;

    localparam logic signed [71:0] SUM_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SUM_MIN = -72'sd2147483648;

    // Values that sit at the corners of Q16.16: both limits, zero, the
    // smallest negative step, plus and minus one.
    localparam logic [31:0] CORNER_VALUES [6] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000
    };

    // ------------------------------------------------------------------------
    // Ports of the core. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    dense_matrix_multiply_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the core: both element stores, which entries have been
    // loaded since reset, and the three size registers.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             last;
    } product_t;

    // One row of the directed table: either a register write or a request.
    // Compute rows with a typed answer carry it in exp_value and exp_sat;
    // they are all 1 x 1 products, so the element is (0, 0) and last.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]    reg_val;
        logic [OP_W-1:0]      op;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic [VAL_W-1:0]     value;
        bit                   typed;
        logic [VAL_W-1:0]     exp_value;
        logic                 exp_sat;
    } step_t;

    logic [VAL_W-1:0]  left_mem   [DIM*DIM];
    logic [VAL_W-1:0]  right_mem  [DIM*DIM];
    bit                left_seen  [DIM*DIM];
    bit                right_seen [DIM*DIM];
    logic [SIZE_W-1:0] rows_reg  = SIZE_RESET;
    logic [SIZE_W-1:0] inner_reg = SIZE_RESET;
    logic [SIZE_W-1:0] cols_reg  = SIZE_RESET;

    // Product elements still owed by the core, oldest first.
    product_t product_due[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // A size of zero acts as one, and a size above the store dimension acts
    // as the full dimension.
    function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DIM)
            return DIM;
        return v;
    endfunction

    // True when every store entry that a compute at the present sizes reads
    // has been loaded since reset. Reading a never-loaded entry is outside
    // what the core promises, so no compute is sent otherwise.
    function automatic bit operands_loaded();
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < nk; k++)
                if (!left_seen[i*DIM + k])
                    return 1'b0;
        for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++)
                if (!right_seen[k*DIM + j])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Works out the whole product matrix in row-major order. Each element is
    // the exact sum of full-width products; the sum is shifted down by the
    // fraction width with rounding toward zero, then clipped to 32 bits.
    function automatic void predict_products();
        int unsigned       nr;
        int unsigned       nk;
        int unsigned       nc;
        longint            prod;
        logic signed [71:0] acc;
        logic signed [71:0] quot;
        product_t          p;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                begin
                    prod = longint'(signed'(left_mem[i*DIM + k]))
                         * longint'(signed'(right_mem[k*DIM + j]));
                    acc  = acc + prod;
                end
                if (acc < 0)
                    quot = -((-acc) >>> FRAC);
                else
                    quot = acc >>> FRAC;
                p.row  = IDX_W'(i);
                p.col  = IDX_W'(j);
                p.last = (i == nr - 1) && (j == nc - 1);
                if (quot > SUM_MAX)
                begin
                    p.value = 32'h7FFF_FFFF;
                    p.sat   = 1'b1;
                end
                else if (quot < SUM_MIN)
                begin
                    p.value = 32'h8000_0000;
                    p.sat   = 1'b1;
                end
                else
                begin
                    p.value = quot[31:0];
                    p.sat   = 1'b0;
                end
                product_due.push_back(p);
            end
        end
    endfunction

    function automatic logic [VAL_W-1:0] random_element();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return CORNER_VALUES[$urandom_range(5)];
        if (pick < 45)
            return VAL_W'($urandom_range(32'h7FFFF) - 32'h40000);
        return $urandom;
    endfunction

    // Drops s_tvalid, waits for every owed element and then lets the core
    // settle, since a load in flight leaves nothing behind to wait for.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (product_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only happen with the core idle.
    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0]    val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT_ROWS:    rows_reg  = val;
            REG_INNER_LENGTH: inner_reg = val;
            REG_RIGHT_COLS:   cols_reg  = val;
            default:          ;
        endcase
    endtask

    // Sends one request and, once the core takes it, applies it to the shadow
    // stores or queues the products it owes. s_tvalid stays high when the
    // next request follows without a gap, so it is never lowered and raised
    // in the same step.
    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c,
                                input logic [VAL_W-1:0] v,
                                input bit               typed     = 1'b0,
                                input logic [VAL_W-1:0] exp_value = '0,
                                input logic             exp_sat   = 1'b0);
        product_t p;
        // The idle pattern follows the progress of the run: first a mostly
        // busy sender against a hesitant receiver, then the reverse, then
        // full speed on both sides.
        if (items_sent < TOTAL_ITEMS / 3)
        begin
            send_idle_pct = 18;
            recv_idle_pct = 45;
        end
        else if (items_sent < 2 * TOTAL_ITEMS / 3)
        begin
            send_idle_pct = 45;
            recv_idle_pct = 18;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, v, c, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
        case (op)
            OP_LOAD_LEFT:
            begin
                left_mem[r*DIM + c]  = v;
                left_seen[r*DIM + c] = 1'b1;
            end
            OP_LOAD_RIGHT:
            begin
                right_mem[r*DIM + c]  = v;
                right_seen[r*DIM + c] = 1'b1;
            end
            OP_COMPUTE:
            begin
                if (typed)
                begin
                    p.row   = '0;
                    p.col   = '0;
                    p.value = exp_value;
                    p.sat   = exp_sat;
                    p.last  = 1'b1;
                    product_due.push_back(p);
                end
                else
                    predict_products();
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side: m_tready is redrawn every cycle, and each accepted element
    // is checked field by field against the oldest owed one.
    // ------------------------------------------------------------------------
    task automatic take_product();
        product_t p;
        if (product_due.size() == 0)
        begin
            report_mismatch($sformatf("element (%0d,%0d) arrived with none owed",
                                      m_tdata[2:0], m_tdata[5:3]));
            return;
        end
        p = product_due.pop_front();
        if (m_tdata[2:0] !== p.row)
            report_mismatch($sformatf("row %0d, expected %0d", m_tdata[2:0], p.row));
        if (m_tdata[5:3] !== p.col)
            report_mismatch($sformatf("col %0d, expected %0d", m_tdata[5:3], p.col));
        if (m_tdata[37:6] !== p.value)
            report_mismatch($sformatf("element (%0d,%0d) value %h, expected %h",
                                      p.row, p.col, m_tdata[37:6], p.value));
        if (m_tuser !== p.sat)
            report_mismatch($sformatf("element (%0d,%0d) saturated %b, expected %b",
                                      p.row, p.col, m_tuser, p.sat));
        if (m_tlast !== p.last)
            report_mismatch($sformatf("element (%0d,%0d) last %b, expected %b",
                                      p.row, p.col, m_tlast, p.last));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready)
                take_product();
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hard stop in case the core hangs.
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [SIZE_W-1:0]    val);
        step_t s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t req_step(input logic [OP_W-1:0]  op,
                                       input logic [IDX_W-1:0] r,
                                       input logic [IDX_W-1:0] c,
                                       input logic [VAL_W-1:0] v);
        step_t s;
        s = '{default: '0};
        s.op    = op;
        s.row   = r;
        s.col   = c;
        s.value = v;
        return s;
    endfunction

    function automatic step_t check_step(input logic [VAL_W-1:0] v, input logic sat);
        step_t s;
        s = '{default: '0};
        s.op        = OP_COMPUTE;
        s.typed     = 1'b1;
        s.exp_value = v;
        s.exp_sat   = sat;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        step_t            plan[$];
        int               entries[$];
        int               pick;
        int               tmp;
        int               keep;
        int               pos;
        int               session;
        int               guard;
        bit               broken;
        bit               reconfigure;
        logic [SIZE_W-1:0] sz [3];
        logic [OP_W-1:0]  noise_op;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Single-element products first, where the answer
        // is plain: unity, both saturation limits, a negative result, and a
        // tiny negative product that rounds toward zero. Then the spare
        // request kind, loads outside the configured sizes, zero sizes and
        // the spare register, and a small 2 x 2 product.
        plan = '{
            cfg_step(REG_LEFT_ROWS, 4'd1),
            cfg_step(REG_INNER_LENGTH, 4'd1),
            cfg_step(REG_RIGHT_COLS, 4'd1),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd0, 32'h0001_0000),
            req_step(OP_LOAD_RIGHT, 3'd0, 3'd0, 32'h0001_0000),
            check_step(32'h0001_0000, 1'b0),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd0, 32'h8000_0000),
            req_step(OP_LOAD_RIGHT, 3'd0, 3'd0, 32'h8000_0000),
            check_step(32'h7FFF_FFFF, 1'b1),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd0, 32'h7FFF_FFFF),
            check_step(32'h8000_0000, 1'b1),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd0, 32'hFFFF_0000),
            req_step(OP_LOAD_RIGHT, 3'd0, 3'd0, 32'h0001_0000),
            check_step(32'hFFFF_0000, 1'b0),
            req_step(OP_LOAD_RIGHT, 3'd0, 3'd0, 32'h0000_8000),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd0, 32'hFFFF_FFFF),
            check_step(32'h0000_0000, 1'b0),
            req_step(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF),
            req_step(OP_LOAD_LEFT, 3'd7, 3'd7, 32'h1234_5678),
            req_step(OP_LOAD_RIGHT, 3'd7, 3'd7, 32'hFFFF_FFFF),
            cfg_step(REG_LEFT_ROWS, 4'd0),
            cfg_step(REG_INNER_LENGTH, 4'd0),
            cfg_step(REG_RIGHT_COLS, 4'd0),
            cfg_step(REG_UNUSED, 4'd15),
            check_step(32'h0000_0000, 1'b0),
            cfg_step(REG_LEFT_ROWS, 4'd2),
            cfg_step(REG_INNER_LENGTH, 4'd2),
            cfg_step(REG_RIGHT_COLS, 4'd2),
            req_step(OP_LOAD_LEFT, 3'd0, 3'd1, 32'h7FFF_FFFF),
            req_step(OP_LOAD_LEFT, 3'd1, 3'd0, 32'h8000_0000),
            req_step(OP_LOAD_LEFT, 3'd1, 3'd1, 32'h0001_8000),
            req_step(OP_LOAD_RIGHT, 3'd0, 3'd1, 32'hFFFE_0000),
            req_step(OP_LOAD_RIGHT, 3'd1, 3'd0, 32'h7FFF_FFFF),
            req_step(OP_LOAD_RIGHT, 3'd1, 3'd1, 32'h8000_0000),
            req_step(OP_COMPUTE, 3'd5, 3'd2, 32'hA5A5_5A5A)
        };
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_size_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_request(plan[i].op, plan[i].row, plan[i].col, plan[i].value,
                             plan[i].typed, plan[i].exp_value, plan[i].exp_sat);
        end

        // Random part. Each session may pick new sizes (mostly small), loads every
        // operand entry not yet loaded plus a random share of the rest in
        // random order, and ends with a compute. Stray requests are mixed in,
        // and some sessions break off before their compute.
        session = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            // The first session uses sizes above the dimension, a later one
            // the exact full size.
            reconfigure = (session == 0) || (session == 9) || ($urandom_range(99) < 60);
            if (reconfigure)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    pick = $urandom_range(99);
                    if (session == 0)
                        sz[n] = 4'd15;
                    else if (session == 9)
                        sz[n] = 4'd8;
                    else if (pick < 70)
                        sz[n] = SIZE_W'($urandom_range(1, 3));
                    else if (pick < 85)
                        sz[n] = SIZE_W'($urandom_range(4, 8));
                    else if (pick < 92)
                        sz[n] = '0;
                    else
                        sz[n] = SIZE_W'($urandom_range(9, 15));
                end
                write_size_reg(REG_LEFT_ROWS, sz[0]);
                write_size_reg(REG_INNER_LENGTH, sz[1]);
                write_size_reg(REG_RIGHT_COLS, sz[2]);
            end

            // Entry codes: the upper half of the code space is the right store.
            entries.delete();
            for (int i = 0; i < eff_dim(rows_reg); i++)
                for (int k = 0; k < eff_dim(inner_reg); k++)
                    if (!left_seen[i*DIM + k] || $urandom_range(1))
                        entries.push_back(i*DIM + k);
            for (int k = 0; k < eff_dim(inner_reg); k++)
                for (int j = 0; j < eff_dim(cols_reg); j++)
                    if (!right_seen[k*DIM + j] || $urandom_range(1))
                        entries.push_back(DIM*DIM + k*DIM + j);
            for (int n = entries.size() - 1; n > 0; n--)
            begin
                pick          = $urandom_range(n);
                tmp           = entries[n];
                entries[n]    = entries[pick];
                entries[pick] = tmp;
            end

            broken = ($urandom_range(99) < 10) && (entries.size() > 1);
            if (broken)
            begin
                keep = $urandom_range(entries.size() - 1);
                while (entries.size() > keep)
                    void'(entries.pop_back());
            end

            foreach (entries[n])
            begin
                if ($urandom_range(99) < 15)
                begin
                    noise_op = OP_W'($urandom_range(3));
                    if (noise_op == OP_COMPUTE && !operands_loaded())
                        noise_op = OP_LOAD_LEFT;
                    send_request(noise_op, IDX_W'($urandom_range(7)),
                                 IDX_W'($urandom_range(7)), random_element());
                end
                pos = entries[n] % (DIM*DIM);
                send_request((entries[n] >= DIM*DIM) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                             IDX_W'(pos / DIM), IDX_W'(pos % DIM), random_element());
            end

            if (!broken)
            begin
                // Now and then hold the compute back until the core has
                // handed over everything it owes.
                if ($urandom_range(99) < 12)
                    drain_results();
                send_request(OP_COMPUTE, IDX_W'($urandom_range(7)),
                             IDX_W'($urandom_range(7)), random_element());
            end
            session++;
        end

        // Wind down: wait for every owed element, then a little longer so a
        // stray extra element would still be seen.
        s_tvalid <= 1'b0;
        guard = 0;
        while (product_due.size() != 0 && guard < END_WAIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (product_due.size() != 0)
            report_mismatch($sformatf("%0d product elements never arrived",
                                      product_due.size()));

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
